// ===== design/text_mode_console_writer_top_assert.svh =====
// ---------------------------------------------------------------------------
// Console writer assertion macros
// Shared concurrent assertion forms; clk and rst_n must be in scope.
// ---------------------------------------------------------------------------
`ifndef TEXT_MODE_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_MODE_CONSOLE_WRITER_TOP_ASSERT_SVH

// check that expr holds at every edge outside reset
`define TMCW_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check that cons holds in the same cycle as ante
`define TMCW_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check that cons holds in the cycle after ante
`define TMCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tmcw_pkg.sv =====
// ---------------------------------------------------------------------------
// Console writer package
// Field widths, codes, defaults and the controller/datapath interface types.
// ---------------------------------------------------------------------------
package tmcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int OP_W      = 2;
  localparam int CHAR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int DATA_W    = 16;
  localparam int ATTR_W    = 8;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;

  typedef struct packed {
    logic latch;
    logic exec;
    logic scr_rd;
    logic scr_wr;
    logic blank_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic is_clear;
    logic copy_last;
    logic blank_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/text_mode_console_writer_top.sv =====
// ---------------------------------------------------------------------------
// Text-mode console writer
// Character-cell screen store with cursor, scroll, clear and cell read.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one transaction per item, op selects put character,
//   clear screen or read cell. Output channel (out_*): exactly one result
//   transaction per item, carrying read data, cursor after the item and the
//   scroll flag. Config channel (cfg_*): always ready; write the attribute
//   only while no item is in flight.
//   Sequence: a put, newline without scroll or read passes the execute and
//   result steps of the controller; the next item is accepted in the result
//   step while that result is loaded into the output register.
//   Scroll: row copy alternates RAM read and write, moving each row below
//   the first up one row; the last row is then blanked.
//   Clear: one cell written per cycle until all COLUMNS*ROWS cells are blank.
//   Reset: cursor homes, attribute returns to 15; the screen store is not
//   cleared and holds unknown data until a clear item.
//   Stall: a finished result sits in the output register; one further item
//   is accepted and executed, then holds in_ready low until that register
//   can be refilled.
// ---------------------------------------------------------------------------
module text_mode_console_writer_top #(
  parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tmcw_pkg::OP_W-1:0]      in_op,
  input  logic [tmcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tmcw_pkg::IDX_W-1:0]     in_cell_index,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tmcw_pkg::ATTR_W-1:0]    cfg_text_attribute,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tmcw_pkg::DATA_W-1:0]    out_read_data,
  output logic [tmcw_pkg::ROW_OUT_W-1:0] out_cursor_row,
  output logic [tmcw_pkg::COL_OUT_W-1:0] out_cursor_col,
  output logic                           out_scrolled
);

  import tmcw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tmcw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  tmcw_dpath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_char_code      (in_char_code),
    .in_cell_index     (in_cell_index),
    .cfg_write         (cfg_valid && cfg_ready),
    .cfg_text_attribute(cfg_text_attribute),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_col    (out_cursor_col),
    .out_scrolled      (out_scrolled)
  );

endmodule

// ===== design/tmcw_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/tmcw_ctrl.sv =====
// ---------------------------------------------------------------------------
// Console writer controller
// Sequences item execution, row copy, blanking and result hand-off.
// ---------------------------------------------------------------------------
`include "text_mode_console_writer_top_assert.svh"

module tmcw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tmcw_pkg::sts_t sts,
  output tmcw_pkg::cmd_t cmd
);

  import tmcw_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_SCR_RD = 6'b000100,
    S_SCR_WR = 6'b001000,
    S_BLANK  = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_scroll) begin
          state_nxt = S_SCR_RD;
        end else if (sts.is_clear) begin
          state_nxt = S_BLANK;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_SCR_RD: begin
        cmd.scr_rd = 1'b1;
        state_nxt  = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd.scr_wr = 1'b1;
        state_nxt  = sts.copy_last ? S_BLANK : S_SCR_RD;
      end
      S_BLANK: begin
        cmd.blank_wr = 1'b1;
        if (sts.blank_last) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          in_ready     = 1'b1;
          if (in_valid) begin
            cmd.latch = 1'b1;
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TMCW_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_r == S_EXEC,
                    "accept without execute")
  `TMCW_ASSERT_ALWAYS(a_state_onehot, $onehot(state_r), "state not one-hot")
  `TMCW_ASSERT_IMPLIES(a_load_free, cmd.load_out, sts.out_free,
                       "result loaded into busy output register")

endmodule

// ===== design/tmcw_dpath.sv =====
// ---------------------------------------------------------------------------
// Console writer datapath
// Screen store, cursor, attribute register, walk counter and result register.
// ---------------------------------------------------------------------------
`include "text_mode_console_writer_top_assert.svh"

module tmcw_dpath #(
  parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tmcw_pkg::cmd_t                 cmd,
  output tmcw_pkg::sts_t                 sts,
  input  logic [tmcw_pkg::OP_W-1:0]      in_op,
  input  logic [tmcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tmcw_pkg::IDX_W-1:0]     in_cell_index,
  input  logic                           cfg_write,
  input  logic [tmcw_pkg::ATTR_W-1:0]    cfg_text_attribute,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tmcw_pkg::DATA_W-1:0]    out_read_data,
  output logic [tmcw_pkg::ROW_OUT_W-1:0] out_cursor_row,
  output logic [tmcw_pkg::COL_OUT_W-1:0] out_cursor_col,
  output logic                           out_scrolled
);

  import tmcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int CMPW  = ((AW > IDX_W) ? AW : IDX_W) + 1;

  logic [OP_W-1:0]    op_r;
  logic [CHAR_W-1:0]  char_r;
  logic [IDX_W-1:0]   idx_r;
  logic [ATTR_W-1:0]  attr_r;
  logic [RW-1:0]      row_r;
  logic [RW-1:0]      row_nxt;
  logic [CW-1:0]      col_r;
  logic [CW-1:0]      col_nxt;
  logic [AW-1:0]      cnt_r;
  logic               scroll_r;
  logic               hit_r;
  logic               out_valid_r;
  logic [DATA_W-1:0]  read_data_r;
  logic [ROW_OUT_W-1:0] row_out_r;
  logic [COL_OUT_W-1:0] col_out_r;
  logic               scrolled_r;

  logic               is_put;
  logic               is_nl;
  logic               is_read;
  logic               col_last;
  logic               row_last;
  logic               adv_row;
  logic               idx_hit;
  logic [AW-1:0]      pos;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [DATA_W-1:0]  wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [DATA_W-1:0]  rd_data;

  assign is_put   = (op_r == OP_PUT);
  assign is_read  = (op_r == OP_READ);
  assign is_nl    = (char_r == NEWLINE_CODE);
  assign col_last = (col_r == CW'(COLUMNS - 1));
  assign row_last = (row_r == RW'(ROWS - 1));
  assign adv_row  = is_put && (is_nl || col_last);
  assign idx_hit  = (CMPW'(idx_r) < CMPW'(CELLS));
  assign pos      = AW'(AW'(row_r) * AW'(COLUMNS) + AW'(col_r));

  assign sts.need_scroll = adv_row && row_last;
  assign sts.is_clear    = (op_r == OP_CLEAR);
  assign sts.copy_last   = (cnt_r == AW'(CELLS - COLUMNS - 1));
  assign sts.blank_last  = (cnt_r == AW'(CELLS - 1));
  assign sts.out_free    = !out_valid_r || out_ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_data = {attr_r, SPACE_CODE};
    rd_en   = 1'b0;
    rd_addr = AW'(idx_r);
    if (cmd.exec) begin
      wr_en   = is_put && !is_nl;
      wr_addr = pos;
      wr_data = {attr_r, char_r};
      rd_en   = is_read && idx_hit;
    end else if (cmd.scr_rd) begin
      rd_en   = 1'b1;
      rd_addr = AW'(cnt_r + AW'(COLUMNS));
    end else if (cmd.scr_wr) begin
      wr_en   = 1'b1;
      wr_data = rd_data;
    end else if (cmd.blank_wr) begin
      wr_en   = 1'b1;
    end
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (sts.is_clear) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (adv_row) begin
      col_nxt = '0;
      row_nxt = row_last ? RW'(ROWS - 1) : RW'(row_r + 1'b1);
    end else if (is_put) begin
      col_nxt = CW'(col_r + 1'b1);
    end
  end

  tmcw_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= ATTR_RESET;
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write) begin
        attr_r <= cfg_text_attribute;
      end
      if (cmd.exec) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
        cnt_r <= '0;
      end else if (cmd.scr_wr || cmd.blank_wr) begin
        cnt_r <= AW'(cnt_r + 1'b1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_op;
      char_r <= in_char_code;
      idx_r  <= in_cell_index;
    end
    if (cmd.exec) begin
      scroll_r <= sts.need_scroll;
      hit_r    <= is_read && idx_hit;
    end
    if (cmd.load_out) begin
      read_data_r <= hit_r ? rd_data : '0;
      row_out_r   <= ROW_OUT_W'(row_r);
      col_out_r   <= COL_OUT_W'(col_r);
      scrolled_r  <= scroll_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = read_data_r;
  assign out_cursor_row = row_out_r;
  assign out_cursor_col = col_out_r;
  assign out_scrolled   = scrolled_r;

  `TMCW_ASSERT_ALWAYS(a_cursor_bounds, (row_r <= RW'(ROWS - 1)) && (col_r <= CW'(COLUMNS - 1)), "cursor out of range")
  `TMCW_ASSERT_IMPLIES(a_write_bounds, wr_en, (AW + 1)'(wr_addr) < (AW + 1)'(CELLS), "write beyond store")
  `TMCW_ASSERT_NEXT(a_scroll_cursor, cmd.exec && sts.need_scroll, row_last && (col_r == '0), "scroll cursor wrong")

endmodule
